// ----- rtl/sqg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqg_pkg
// Shared types and constants for the two-qubit gate unit over a stored state
// vector.
// ----------------------------------------------------------------------------
package sqg_pkg;

    localparam int MAX_QUBITS_DEF = 10;
    localparam int AMP_WIDTH_DEF  = 16;

    localparam int CMD_W   = 3;
    localparam int INDEX_W = 10;
    localparam int FIELD_W = 16;
    localparam int QUBIT_W = 4;
    localparam int STAT_W  = 2;
    localparam int QC_W    = 4;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 40;

    localparam logic [QC_W-1:0] QC_RESET = 4'd10;

    localparam logic [CMD_W-1:0] CMD_WRITE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CZ    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SWAP  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CNOT  = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_EQUAL = 2'd2;

    typedef struct packed {
        logic [QUBIT_W-1:0] qubit_b;
        logic [QUBIT_W-1:0] qubit_a;
        logic [FIELD_W-1:0] amp_imag;
        logic [FIELD_W-1:0] amp_real;
        logic [INDEX_W-1:0] amp_index;
        logic [CMD_W-1:0]   cmd;
    } request_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [FIELD_W-1:0] read_imag;
        logic [FIELD_W-1:0] read_real;
    } result_t;

endpackage

// ----- rtl/sqg_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqg_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sqg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/sqg_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqg_ctrl
// Command sequencer: single amplitude access and read-modify-write walks of
// the amplitude memory for CZ, SWAP and CNOT.
// ----------------------------------------------------------------------------
module sqg_ctrl #(
    parameter int MAX_QUBITS = sqg_pkg::MAX_QUBITS_DEF,
    parameter int AMP_WIDTH  = sqg_pkg::AMP_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [sqg_pkg::QC_W-1:0]    qubit_count,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  sqg_pkg::request_t           req,
    output logic                        res_valid,
    input  logic                        res_ready,
    output sqg_pkg::result_t            res,
    output logic                        mem_we,
    output logic [MAX_QUBITS-1:0]       mem_waddr,
    output logic [2*AMP_WIDTH-1:0]      mem_wdata,
    output logic [MAX_QUBITS-1:0]       mem_raddr,
    input  logic [2*AMP_WIDTH-1:0]      mem_rdata
);
    import sqg_pkg::*;

    localparam int NW = $clog2(MAX_QUBITS + 1);
    localparam int AW = AMP_WIDTH;
    localparam logic [MAX_QUBITS-1:0] MQ_ONE = MAX_QUBITS'(1);
    localparam logic [AW-1:0] AMP_MIN = {1'b1, {(AW-1){1'b0}}};
    localparam logic [AW-1:0] AMP_MAX = {1'b0, {(AW-1){1'b1}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_SCAN,
        S_CZ_WR,
        S_PR_RDJ,
        S_PR_WRJ,
        S_PR_WRI,
        S_DONE
    } state_t;

    state_t                  state_reg;
    logic [CMD_W-1:0]        cmd_reg;
    logic [STAT_W-1:0]       status_reg;
    logic                    mem_op_reg;
    logic [MAX_QUBITS-1:0]   addr_reg;
    logic [2*AW-1:0]         word_reg;
    logic [MAX_QUBITS-1:0]   mask_a_reg;
    logic [MAX_QUBITS-1:0]   mask_b_reg;
    logic [MAX_QUBITS-1:0]   last_reg;
    logic [MAX_QUBITS-1:0]   cnt_reg;
    logic [2*AW-1:0]         hold_reg;

    logic [NW-1:0]           n;
    logic                    idx_bad;
    logic                    qa_bad;
    logic                    qb_bad;
    logic [NW-1:0]           pos_a;
    logic [NW-1:0]           pos_b;
    logic [STAT_W-1:0]       status_next;
    logic                    mem_op_next;
    logic                    gate_next;
    logic [MAX_QUBITS-1:0]   last_next;
    logic                    hit_a;
    logic                    hit_b;
    logic [MAX_QUBITS-1:0]   pair_addr;
    logic                    at_last;
    logic [AW-1:0]           neg_re;
    logic [AW-1:0]           neg_im;
    logic                    is_read;

    function automatic logic [AW-1:0] neg_sat(input logic [AW-1:0] v);
        logic [AW-1:0] r;
        if (v == AMP_MIN)
        begin
            r = AMP_MAX;
        end
        else
        begin
            r = -v;
        end
        return r;
    endfunction

    always_comb
    begin
        if (qubit_count == '0)
        begin
            n = NW'(1);
        end
        else if (32'(qubit_count) > 32'(MAX_QUBITS))
        begin
            n = NW'(MAX_QUBITS);
        end
        else
        begin
            n = NW'(qubit_count);
        end
    end

    assign idx_bad   = ((32'(req.amp_index) >> n) != 32'd0);
    assign qa_bad    = (32'(req.qubit_a) >= 32'(n));
    assign qb_bad    = (32'(req.qubit_b) >= 32'(n));
    assign pos_a     = n - NW'(1) - NW'(req.qubit_a);
    assign pos_b     = n - NW'(1) - NW'(req.qubit_b);
    assign last_next = (MQ_ONE << n) - MQ_ONE;

    always_comb
    begin
        status_next = ST_OK;
        mem_op_next = 1'b0;
        gate_next   = 1'b0;
        unique case (req.cmd)
            CMD_WRITE, CMD_READ:
            begin
                if (idx_bad)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    mem_op_next = 1'b1;
                end
            end
            CMD_CZ, CMD_SWAP, CMD_CNOT:
            begin
                if (qa_bad || qb_bad)
                begin
                    status_next = ST_RANGE;
                end
                else if (req.qubit_a == req.qubit_b)
                begin
                    status_next = (req.cmd == CMD_SWAP) ? ST_OK : ST_EQUAL;
                end
                else
                begin
                    gate_next = 1'b1;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    assign hit_a     = |(cnt_reg & mask_a_reg);
    assign hit_b     = |(cnt_reg & mask_b_reg);
    assign pair_addr = (cmd_reg == CMD_SWAP) ? (cnt_reg ^ mask_a_reg ^ mask_b_reg)
                                             : (cnt_reg | mask_b_reg);
    assign at_last   = (cnt_reg == last_reg);
    assign neg_re    = neg_sat(mem_rdata[AW-1:0]);
    assign neg_im    = neg_sat(mem_rdata[2*AW-1:AW]);
    assign is_read   = mem_op_reg && (cmd_reg == CMD_READ);

    // memory port drive
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cnt_reg;
        mem_wdata = hold_reg;
        mem_raddr = cnt_reg;
        unique case (state_reg)
            S_RD:
            begin
                mem_raddr = addr_reg;
            end
            S_DONE:
            begin
                mem_raddr = addr_reg;
                mem_waddr = addr_reg;
                mem_wdata = word_reg;
                mem_we    = mem_op_reg && (cmd_reg == CMD_WRITE);
            end
            S_CZ_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = {neg_im, neg_re};
            end
            S_PR_RDJ:
            begin
                mem_raddr = pair_addr;
            end
            S_PR_WRJ:
            begin
                mem_we    = 1'b1;
                mem_waddr = pair_addr;
            end
            S_PR_WRI:
            begin
                mem_we    = 1'b1;
            end
            default:
            begin
                mem_we    = 1'b0;
            end
        endcase
    end

    assign req_ready     = (state_reg == S_IDLE);
    assign res_valid     = (state_reg == S_DONE);
    assign res.status    = status_reg;
    assign res.read_real = is_read ? FIELD_W'(mem_rdata[AW-1:0]) : '0;
    assign res.read_imag = is_read ? FIELD_W'(mem_rdata[2*AW-1:AW]) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        if (gate_next)
                        begin
                            state_reg <= S_SCAN;
                        end
                        else if (mem_op_next && (req.cmd == CMD_READ))
                        begin
                            state_reg <= S_RD;
                        end
                        else
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_RD:
                begin
                    state_reg <= S_DONE;
                end
                S_SCAN:
                begin
                    if ((cmd_reg == CMD_CZ) && hit_a && hit_b)
                    begin
                        state_reg <= S_CZ_WR;
                    end
                    else if ((cmd_reg != CMD_CZ) && hit_a && !hit_b)
                    begin
                        state_reg <= S_PR_RDJ;
                    end
                    else if (at_last)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_CZ_WR, S_PR_WRI:
                begin
                    state_reg <= at_last ? S_DONE : S_SCAN;
                end
                S_PR_RDJ:
                begin
                    state_reg <= S_PR_WRJ;
                end
                S_PR_WRJ:
                begin
                    state_reg <= S_PR_WRI;
                end
                S_DONE:
                begin
                    if (res_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // request fields and walk registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && req_valid)
        begin
            cmd_reg    <= req.cmd;
            status_reg <= status_next;
            mem_op_reg <= mem_op_next;
            addr_reg   <= MAX_QUBITS'(req.amp_index);
            word_reg   <= {AW'(req.amp_imag), AW'(req.amp_real)};
            mask_a_reg <= MQ_ONE << pos_a;
            mask_b_reg <= MQ_ONE << pos_b;
            last_reg   <= last_next;
            cnt_reg    <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_SCAN:
                begin
                    if (!(((cmd_reg == CMD_CZ) && hit_a && hit_b)
                          || ((cmd_reg != CMD_CZ) && hit_a && !hit_b)))
                    begin
                        cnt_reg <= cnt_reg + MQ_ONE;
                    end
                end
                S_CZ_WR, S_PR_WRI:
                begin
                    cnt_reg <= cnt_reg + MQ_ONE;
                end
                S_PR_RDJ, S_PR_WRJ:
                begin
                    hold_reg <= mem_rdata;
                end
                default:
                begin
                    cnt_reg <= cnt_reg;
                end
            endcase
        end
    end

endmodule

// ----- rtl/state_vector_two_qubit_gates_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// state_vector_two_qubit_gates_unit
// Quantum state vector store with amplitude write/read and CZ, SWAP, CNOT.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// s_axis    in         cmd, amp_index, amp_real, amp_imag, qubit_a, qubit_b
// m_axis    out        read_real, read_imag, status
// cfg       in         qubit_count
//
// Write goes straight to the result; a read first waits in S_RD for the registered memory read.
// Gates walk each index of the 2^n vector, with an extra write state per CZ
// entry and a read and two write states per exchanged pair; the single memory port pair sets this.
// The output register frees the sequencer; it holds a finished result
// while the next request runs. No clearing pass after reset.
// ----------------------------------------------------------------------------
module state_vector_two_qubit_gates_unit #(
    parameter int MAX_QUBITS = sqg_pkg::MAX_QUBITS_DEF,
    parameter int AMP_WIDTH  = sqg_pkg::AMP_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [sqg_pkg::QC_W-1:0]           cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // cmd, amp_index, amp_real, amp_imag, qubit_a, qubit_b, zero pad
    input  logic [sqg_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // read_real, read_imag, status, zero pad
    output logic [sqg_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import sqg_pkg::*;

    localparam int REQ_W = $bits(request_t);
    localparam int RES_W = $bits(result_t);

    logic [QC_W-1:0]        qc_reg;
    logic                   out_valid_reg;
    result_t                out_reg;
    request_t               req;
    result_t                res;
    logic                   res_valid;
    logic                   res_ready;
    logic                   mem_we;
    logic [MAX_QUBITS-1:0]  mem_waddr;
    logic [2*AMP_WIDTH-1:0] mem_wdata;
    logic [MAX_QUBITS-1:0]  mem_raddr;
    logic [2*AMP_WIDTH-1:0] mem_rdata;

    assign req       = request_t'(s_axis_tdata[REQ_W-1:0]);
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qc_reg        <= QC_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                qc_reg <= cfg_wdata;
            end
            if (res_ready)
            begin
                out_valid_reg <= res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-RES_W){1'b0}}, out_reg};

    sqg_ctrl #(
        .MAX_QUBITS (MAX_QUBITS),
        .AMP_WIDTH  (AMP_WIDTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .qubit_count (qc_reg),
        .req_valid   (s_axis_tvalid),
        .req_ready   (s_axis_tready),
        .req         (req),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

    sqg_ram #(
        .WIDTH (2*AMP_WIDTH),
        .DEPTH (2**MAX_QUBITS)
    ) u_amp_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-qubit gate unit. Tracks its own copy of the
// amplitude store and qubit count, predicts one result per accepted request
// and checks every result in order. The bench fills the vector before gating
// or reading it, then runs directed corner cases and randomized phases over
// several qubit counts, with random gaps on the request side and random
// stalls on the result side.
// ----------------------------------------------------------------------------
module testbench;
    import sqg_pkg::*;

    localparam int DEPTH      = 1 << MAX_QUBITS_DEF;
    localparam int CYCLE_CAP  = 1000000;
    localparam int NUM_PHASES = 11;

    class gate_outcome_book;
        logic [FIELD_W-1:0] amp_re [DEPTH];
        logic [FIELD_W-1:0] amp_im [DEPTH];
        logic [QC_W-1:0]    qubit_count;
        result_t            due_results [$];
        int                 mismatches;

        function new();
            qubit_count = QC_RESET;
            mismatches  = 0;
            foreach (amp_re[i])
            begin
                amp_re[i] = '0;
                amp_im[i] = '0;
            end
        endfunction

        function void set_qubit_count(logic [QC_W-1:0] v);
            qubit_count = v;
        endfunction

        function int active_qubits();
            if (qubit_count < 1)
                return 1;
            if (qubit_count > MAX_QUBITS_DEF)
                return MAX_QUBITS_DEF;
            return int'(qubit_count);
        endfunction

        function int outstanding();
            return due_results.size();
        endfunction

        function logic [FIELD_W-1:0] negate_sat(logic [FIELD_W-1:0] v);
            if (v == {1'b1, {(FIELD_W-1){1'b0}}})
                return {1'b0, {(FIELD_W-1){1'b1}}};
            return FIELD_W'(-v);
        endfunction

        function void exchange(int x, int y);
            logic [FIELD_W-1:0] t;
            t = amp_re[x]; amp_re[x] = amp_re[y]; amp_re[y] = t;
            t = amp_im[x]; amp_im[x] = amp_im[y]; amp_im[y] = t;
        endfunction

        function void note_request(request_t r);
            result_t res;
            int      n;
            int      dim;
            int      ba;
            int      bb;
            res = '0;
            n   = active_qubits();
            dim = 1 << n;
            if (r.cmd == CMD_WRITE || r.cmd == CMD_READ)
            begin
                if (r.amp_index >= dim)
                    res.status = ST_RANGE;
                else if (r.cmd == CMD_WRITE)
                begin
                    amp_re[r.amp_index] = r.amp_real;
                    amp_im[r.amp_index] = r.amp_imag;
                end
                else
                begin
                    res.read_real = amp_re[r.amp_index];
                    res.read_imag = amp_im[r.amp_index];
                end
            end
            else if (r.cmd == CMD_CZ || r.cmd == CMD_SWAP || r.cmd == CMD_CNOT)
            begin
                if (r.qubit_a >= n || r.qubit_b >= n)
                    res.status = ST_RANGE;
                else if (r.qubit_a == r.qubit_b)
                    res.status = (r.cmd == CMD_SWAP) ? ST_OK : ST_EQUAL;
                else
                begin
                    ba = 1 << (n - 1 - int'(r.qubit_a));
                    bb = 1 << (n - 1 - int'(r.qubit_b));
                    for (int i = 0; i < dim; i++)
                    begin
                        if ((i & ba) != 0 && r.cmd == CMD_CZ && (i & bb) != 0)
                        begin
                            amp_re[i] = negate_sat(amp_re[i]);
                            amp_im[i] = negate_sat(amp_im[i]);
                        end
                        else if ((i & ba) != 0 && (i & bb) == 0 && r.cmd == CMD_SWAP)
                            exchange(i, i ^ ba ^ bb);
                        else if ((i & ba) != 0 && (i & bb) == 0 && r.cmd == CMD_CNOT)
                            exchange(i, i | bb);
                    end
                end
            end
            due_results.push_back(res);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (due_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: re=%h im=%h st=%0d",
                             got.read_real, got.read_imag, got.status);
                return;
            end
            want = due_results.pop_front();
            if (got.read_real !== want.read_real || got.read_imag !== want.read_imag ||
                got.status !== want.status)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: exp re=%h im=%h st=%0d, got re=%h im=%h st=%0d",
                             want.read_real, want.read_imag, want.status,
                             got.read_real, got.read_imag, got.status);
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [QC_W-1:0]        cfg_wdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    gate_outcome_book book;
    bit               idle_on;
    bit               written [DEPTH];
    int               cycles;

    state_vector_two_qubit_gates_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        idle_on       = 1'b1;
        cycles        = 0;
        book          = new();
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result-side stalls
    always @(posedge clk)
        m_axis_tready <= !idle_on || ($urandom_range(99) >= 37);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                book.check_result(result_t'(m_axis_tdata[$bits(result_t)-1:0]));
            if (s_axis_tvalid && s_axis_tready)
                book.note_request(request_t'(s_axis_tdata[$bits(request_t)-1:0]));
        end
    end

    function automatic request_t make_req(logic [CMD_W-1:0] cmd, int idx,
                                          logic [FIELD_W-1:0] re, logic [FIELD_W-1:0] im,
                                          int qa, int qb);
        request_t r;
        r.cmd       = cmd;
        r.amp_index = INDEX_W'(idx);
        r.amp_real  = re;
        r.amp_imag  = im;
        r.qubit_a   = QUBIT_W'(qa);
        r.qubit_b   = QUBIT_W'(qb);
        return r;
    endfunction

    function automatic logic [FIELD_W-1:0] rand_amp();
        case ($urandom_range(19))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return FIELD_W'($urandom);
        endcase
    endfunction

    // valid stays high across back-to-back requests; lowered for a gap or by wait_idle
    task automatic send_request(request_t r);
        int gap;
        if (idle_on && $urandom_range(99) < 37)
        begin
            s_axis_tvalid <= 1'b0;
            gap = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'(r);
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (r.cmd == CMD_WRITE && r.amp_index < (1 << book.active_qubits()))
            written[r.amp_index] = 1'b1;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (book.outstanding() != 0);
    endtask

    task automatic program_qubits(logic [QC_W-1:0] v);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        book.set_qubit_count(v);
    endtask

    task automatic fill_vector();
        int dim;
        dim = 1 << book.active_qubits();
        for (int i = 0; i < dim; i++)
            if (!written[i])
                send_request(make_req(CMD_WRITE, i, rand_amp(), rand_amp(), 0, 0));
    endtask

    task automatic random_request();
        request_t r;
        int       n;
        int       dim;
        int       pick;
        n    = book.active_qubits();
        dim  = 1 << n;
        r    = make_req(CMD_WRITE, $urandom_range(DEPTH - 1), rand_amp(), rand_amp(),
                        $urandom_range(15), $urandom_range(15));
        pick = $urandom_range(99);
        if (pick < 64)
        begin
            r.cmd = (pick < 32) ? CMD_WRITE : CMD_READ;
            if ($urandom_range(9) != 0)
                r.amp_index = INDEX_W'($urandom_range(dim - 1));
        end
        else if (pick < 94)
        begin
            case ($urandom_range(2))
                0: r.cmd = CMD_CZ;
                1: r.cmd = CMD_SWAP;
                default: r.cmd = CMD_CNOT;
            endcase
            pick = $urandom_range(99);
            if (pick < 75 && n >= 2)
            begin
                r.qubit_a = QUBIT_W'($urandom_range(n - 1));
                r.qubit_b = QUBIT_W'((int'(r.qubit_a) + 1 + $urandom_range(n - 2)) % n);
            end
            else if (pick < 88)
            begin
                r.qubit_a = QUBIT_W'($urandom_range(n - 1));
                r.qubit_b = r.qubit_a;
            end
        end
        else
            r.cmd = CMD_W'($urandom_range(5, 7));
        send_request(r);
    endtask

    initial
    begin
        logic [QC_W-1:0] phase_qc [NUM_PHASES];
        phase_qc = '{4'd3, 4'd0, 4'd1, 4'd5, 4'd15, 4'd4, 4'd2, 4'd10, 4'd7, 4'd6, 4'd3};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset qubit count of ten
        send_request(make_req(CMD_CZ, 0, 16'h0, 16'h0, 9, 9));
        send_request(make_req(CMD_CNOT, 0, 16'h0, 16'h0, 10, 0));
        send_request(make_req(CMD_WRITE, 1023, 16'h8000, 16'h7fff, 0, 0));
        send_request(make_req(CMD_READ, 1023, 16'h0, 16'h0, 0, 0));

        program_qubits(4'd2);
        send_request(make_req(CMD_WRITE, 0, 16'h7fff, 16'h8000, 0, 0));
        send_request(make_req(CMD_WRITE, 1, 16'h0000, 16'hffff, 0, 0));
        send_request(make_req(CMD_WRITE, 2, 16'h8000, 16'h0001, 0, 0));
        send_request(make_req(CMD_WRITE, 3, 16'h8000, 16'h8000, 0, 0));
        send_request(make_req(CMD_WRITE, 4, 16'h1234, 16'h5678, 0, 0));
        send_request(make_req(CMD_READ, 1023, 16'h0, 16'h0, 0, 0));
        send_request(make_req(CMD_CZ, 0, 16'h0, 16'h0, 0, 1));
        send_request(make_req(CMD_CZ, 0, 16'h0, 16'h0, 1, 1));
        send_request(make_req(CMD_SWAP, 0, 16'h0, 16'h0, 0, 0));
        send_request(make_req(CMD_CNOT, 0, 16'h0, 16'h0, 1, 1));
        send_request(make_req(CMD_SWAP, 0, 16'h0, 16'h0, 0, 1));
        send_request(make_req(CMD_CNOT, 0, 16'h0, 16'h0, 0, 1));
        send_request(make_req(CMD_CNOT, 0, 16'h0, 16'h0, 1, 0));
        send_request(make_req(CMD_SWAP, 0, 16'h0, 16'h0, 2, 15));
        send_request(make_req(CMD_CZ, 0, 16'h0, 16'h0, 15, 0));
        send_request(make_req(3'd5, 512, 16'h4000, 16'hc000, 1, 0));
        send_request(make_req(3'd6, 0, 16'h0, 16'h0, 0, 1));
        send_request(make_req(3'd7, 1023, 16'hffff, 16'hffff, 15, 15));
        for (int i = 0; i < 4; i++)
            send_request(make_req(CMD_READ, i, 16'h0, 16'h0, 0, 0));

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            program_qubits(phase_qc[p]);
            idle_on = (p != 3);
            fill_vector();
            repeat ((book.active_qubits() >= 8) ? 30 : 50)
                random_request();
        end
        idle_on = 1'b1;

        wait_idle();
        repeat (20) @(posedge clk);
        if (book.mismatches == 0 && book.outstanding() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/sqg_pkg.sv
rtl/sqg_ram.sv
rtl/sqg_ctrl.sv
rtl/state_vector_two_qubit_gates_unit.sv
verif/testbench.sv
